FILE: design/ipal_pkg.sv
package ipal_pkg;

  // Table depth and derived widths
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 64;
  localparam int PLEN_W   = 8;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Maximum prefix lengths per family
  localparam logic [PLEN_W-1:0] PLEN_MAX_V4 = 8'd32;
  localparam logic [PLEN_W-1:0] PLEN_MAX_V6 = 8'd128;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic scan_step;
    logic exec_write;
    logic load_out;
  } ipal_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_lookup;
    logic hit;
    logic last;
  } ipal_stat_t;

  // Mask with the top n of 64 bits set, n clamped to 0..64
  function automatic logic [ADDR_W-1:0] top_mask64(input logic [PLEN_W-1:0] n);
    logic [ADDR_W-1:0] m;
    if (n == '0) begin
      m = '0;
    end else if (n >= PLEN_W'(ADDR_W)) begin
      m = '1;
    end else begin
      m = ~(ADDR_W'(0)) << (PLEN_W'(ADDR_W) - n);
    end
    return m;
  endfunction

endpackage

FILE: design/ipal_if.sv
interface ipal_in_if;
  logic                          valid;
  logic                          ready;
  logic [ipal_pkg::CMD_W-1:0]    command;
  logic                          is_ipv6;
  logic [ipal_pkg::ADDR_W-1:0]   address_high;
  logic [ipal_pkg::ADDR_W-1:0]   address_low;
  logic [ipal_pkg::PLEN_W-1:0]   prefix_length;

  modport source (
    output valid, command, is_ipv6, address_high, address_low, prefix_length,
    input  ready
  );
  modport sink (
    input  valid, command, is_ipv6, address_high, address_low, prefix_length,
    output ready
  );
endinterface

interface ipal_out_if;
  logic                          valid;
  logic                          ready;
  logic                          matched;
  logic [ipal_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, matched, status,
    input  ready
  );
  modport sink (
    input  valid, matched, status,
    output ready
  );
endinterface

FILE: design/ipal_ctrl.sv
module ipal_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipal_pkg::ipal_cmd_t  cmd,
  input  ipal_pkg::ipal_stat_t stat
);
  import ipal_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Sequence accept, execute or scan, then hand off to the output register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (stat.op_lookup) begin
          cmd.scan_step = 1'b1;
          if (stat.hit || stat.last) begin
            state_nxt = ST_DONE;
          end
        end else begin
          cmd.exec_write = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/ipal_dp.sv
module ipal_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ipal_pkg::CMD_W-1:0]     in_command,
  input  logic                           in_is_ipv6,
  input  logic [ipal_pkg::ADDR_W-1:0]    in_address_high,
  input  logic [ipal_pkg::ADDR_W-1:0]    in_address_low,
  input  logic [ipal_pkg::PLEN_W-1:0]    in_prefix_length,
  input  ipal_pkg::ipal_cmd_t            cmd,
  output ipal_pkg::ipal_stat_t           stat,
  output logic                           out_matched,
  output logic [ipal_pkg::STATUS_W-1:0]  out_status
);
  import ipal_pkg::*;

  // Latched item
  logic [CMD_W-1:0]  cmd_r;
  logic              v6_r;
  logic [ADDR_W-1:0] hi_r;
  logic [ADDR_W-1:0] lo_r;
  logic [PLEN_W-1:0] plen_r;

  // Prefix table; entries below count_r are valid
  logic              ent_v6_r   [TABLE_ENTRIES];
  logic [ADDR_W-1:0] ent_hi_r   [TABLE_ENTRIES];
  logic [ADDR_W-1:0] ent_lo_r   [TABLE_ENTRIES];
  logic [PLEN_W-1:0] ent_plen_r [TABLE_ENTRIES];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Scan pointer and result
  logic [IDX_W-1:0]    idx_r;
  logic                match_r;
  logic [STATUS_W-1:0] status_r;
  logic                out_matched_r;
  logic [STATUS_W-1:0] out_status_r;

  logic              sel_v6;
  logic [ADDR_W-1:0] sel_hi;
  logic [ADDR_W-1:0] sel_lo;
  logic [PLEN_W-1:0] sel_plen;
  logic [ADDR_W-1:0] mask_hi;
  logic [ADDR_W-1:0] mask_lo;
  logic [ADDR_W-1:0] mask_v4;
  logic              covers;
  logic              plen_bad;
  logic              tbl_full;
  logic [IDX_W-1:0]  wr_idx;

  // Read the entry under the scan pointer and test coverage
  always_comb begin
    sel_v6   = ent_v6_r[idx_r];
    sel_hi   = ent_hi_r[idx_r];
    sel_lo   = ent_lo_r[idx_r];
    sel_plen = ent_plen_r[idx_r];
    mask_hi  = top_mask64(sel_plen);
    mask_lo  = (sel_plen > PLEN_W'(ADDR_W)) ? top_mask64(sel_plen - PLEN_W'(ADDR_W)) : '0;
    mask_v4  = mask_hi >> (ADDR_W / 2);
    if (sel_v6 != v6_r) begin
      covers = 1'b0;
    end else if (v6_r) begin
      covers = (((sel_hi ^ hi_r) & mask_hi) == '0) && (((sel_lo ^ lo_r) & mask_lo) == '0);
    end else begin
      covers = ((sel_lo ^ lo_r) & mask_v4) == '0;
    end
  end

  assign stat.op_lookup = (cmd_r == CMD_LOOKUP);
  assign stat.hit       = (count_r != '0) && covers;
  assign stat.last      = (count_r == '0) || (CNT_W'(idx_r) == count_r - CNT_W'(1));

  assign plen_bad = plen_r > (v6_r ? PLEN_MAX_V6 : PLEN_MAX_V4);
  assign tbl_full = count_r >= CNT_W'(TABLE_ENTRIES);
  assign wr_idx   = count_r[IDX_W-1:0];

  // Count update for insert and clear
  always_comb begin
    count_nxt = count_r;
    if (cmd.exec_write) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (!plen_bad && !tbl_full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Latch the accepted beat, run the scan, build the result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r    <= in_command;
      v6_r     <= in_is_ipv6;
      hi_r     <= in_address_high;
      lo_r     <= in_address_low;
      plen_r   <= in_prefix_length;
      idx_r    <= '0;
      match_r  <= 1'b0;
      status_r <= STAT_OK;
    end
    if (cmd.scan_step) begin
      idx_r   <= idx_r + IDX_W'(1);
      match_r <= match_r | stat.hit;
    end
    if (cmd.exec_write && (cmd_r == CMD_INSERT)) begin
      if (plen_bad) begin
        status_r <= STAT_RANGE;
      end else if (tbl_full) begin
        status_r <= STAT_FULL;
      end
    end
    if (cmd.load_out) begin
      out_matched_r <= match_r;
      out_status_r  <= status_r;
    end
  end

  // Append a new entry at the fill position
  always_ff @(posedge clk) begin
    if (cmd.exec_write && (cmd_r == CMD_INSERT) && !plen_bad && !tbl_full) begin
      ent_v6_r[wr_idx]   <= v6_r;
      ent_hi_r[wr_idx]   <= v6_r ? hi_r : '0;
      ent_lo_r[wr_idx]   <= v6_r ? lo_r : {{(ADDR_W / 2){1'b0}}, lo_r[ADDR_W/2-1:0]};
      ent_plen_r[wr_idx] <= plen_r;
    end
  end

  assign out_matched = out_matched_r;
  assign out_status  = out_status_r;

endmodule

FILE: design/ip_prefix_allow_list_core.sv
// IPv4/IPv6 prefix allow list.
// in_ch carries one command beat: lookup, insert or clear, with family,
// 128-bit address and prefix length. out_ch returns one beat per command
// with matched and status. Both channels use valid/ready; a beat moves when
// both are high.
// Insert appends an entry (status 2 if the prefix is too long for the
// family, status 1 if the table is full). Clear empties the table. Lookup
// reports whether any stored prefix of the same family covers the address.
// Insert, clear and the unused code execute in the busy state, then their
// result moves to the output register. A lookup walks the stored entries one
// per cycle through a single compare unit and stops at the first hit or at
// the last stored entry (at most TABLE_ENTRIES = 16).
// A new command is not accepted while one is in flight; the input is taken
// again as soon as the result has moved into the output register.
// Reset empties the table and drops any beat in flight. When the receiver
// stalls, the result holds in the output register; the next command is
// still accepted and its result waits until the register frees.
module ip_prefix_allow_list_core (
  input  logic       clk,
  input  logic       rst_n,
  ipal_in_if.sink    in_ch,
  ipal_out_if.source out_ch
);
  import ipal_pkg::*;

  ipal_cmd_t  cmd;
  ipal_stat_t stat;

  // Sequence each command
  ipal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold the table and compare entries
  ipal_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_ch.command),
    .in_is_ipv6       (in_ch.is_ipv6),
    .in_address_high  (in_ch.address_high),
    .in_address_low   (in_ch.address_low),
    .in_prefix_length (in_ch.prefix_length),
    .cmd              (cmd),
    .stat             (stat),
    .out_matched      (out_ch.matched),
    .out_status       (out_ch.status)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ipal_pkg::*;

  // Code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic                matched;
    logic [STATUS_W-1:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ipal_in_if  in_ch ();
  ipal_out_if out_ch ();

  ip_prefix_allow_list_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the prefix table
  logic              tbl_valid [TABLE_ENTRIES];
  logic              tbl_v6    [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_hi    [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_lo    [TABLE_ENTRIES];
  logic [PLEN_W-1:0] tbl_plen  [TABLE_ENTRIES];
  int                tbl_count = 0;

  verdict_t verdicts_due[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_idle_pct  = 0;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
    end
  end

  // Top n bits of a 128-bit address set
  function automatic logic [127:0] lead_ones128(input int n);
    if (n <= 0) return '0;
    if (n >= 128) return '1;
    return ~128'd0 << (128 - n);
  endfunction

  function automatic logic entry_covers(input int i, input logic v6,
                                        input logic [ADDR_W-1:0] hi,
                                        input logic [ADDR_W-1:0] lo);
    logic [127:0] keep;
    keep = lead_ones128(int'(tbl_plen[i]));
    if (!tbl_valid[i] || tbl_v6[i] != v6) return 1'b0;
    if (v6) return ((({tbl_hi[i], tbl_lo[i]} ^ {hi, lo}) & keep) == '0);
    return (((tbl_lo[i][31:0] ^ lo[31:0]) & keep[127:96]) == '0);
  endfunction

  // Update the shadow table and return the verdict for one command beat
  function automatic verdict_t apply_to_table(input logic [CMD_W-1:0] cmd,
                                              input logic v6,
                                              input logic [ADDR_W-1:0] hi,
                                              input logic [ADDR_W-1:0] lo,
                                              input logic [PLEN_W-1:0] plen);
    verdict_t v;
    int       len_max;
    v.matched = 1'b0;
    v.status  = STAT_OK;
    case (cmd)
      CMD_LOOKUP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (entry_covers(i, v6, hi, lo)) v.matched = 1'b1;
        end
      end
      CMD_INSERT: begin
        len_max = v6 ? int'(PLEN_MAX_V6) : int'(PLEN_MAX_V4);
        if (int'(plen) > len_max) begin
          v.status = STAT_RANGE;
        end else if (tbl_count >= TABLE_ENTRIES) begin
          v.status = STAT_FULL;
        end else begin
          tbl_valid[tbl_count] = 1'b1;
          tbl_v6[tbl_count]    = v6;
          tbl_hi[tbl_count]    = v6 ? hi : '0;
          tbl_lo[tbl_count]    = v6 ? lo : {32'd0, lo[31:0]};
          tbl_plen[tbl_count]  = plen;
          tbl_count++;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          tbl_valid[i] = 1'b0;
        end
        tbl_count = 0;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Drive one command beat, hold it until accepted, then predict its result
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic v6,
                           input logic [ADDR_W-1:0] hi,
                           input logic [ADDR_W-1:0] lo,
                           input logic [PLEN_W-1:0] plen);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.is_ipv6       <= v6;
    in_ch.address_high  <= hi;
    in_ch.address_low   <= lo;
    in_ch.prefix_length <= plen;
    do @(posedge clk); while (!in_ch.ready);
    verdicts_due.push_back(apply_to_table(cmd, v6, hi, lo, plen));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Result beats against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.matched !== want.matched)
          report_mismatch($sformatf("matched %0b, want %0b", out_ch.matched, want.matched));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_insert();
    logic         v6;
    int           len_max;
    int           pick;
    int           j;
    logic [127:0] addr;
    logic [PLEN_W-1:0] plen;
    v6      = 1'($urandom_range(1));
    len_max = v6 ? int'(PLEN_MAX_V6) : int'(PLEN_MAX_V4);
    pick    = $urandom_range(99);
    if (pick < 10) plen = PLEN_W'($urandom_range(len_max + 1, 255));
    else if (pick < 20) plen = $urandom_range(1) ? PLEN_W'(len_max) : '0;
    else plen = PLEN_W'($urandom_range(len_max));
    addr = {rand64(), rand64()};
    // Reuse a stored address now and then to build duplicates
    if (tbl_count > 0 && $urandom_range(99) < 20) begin
      j    = $urandom_range(tbl_count - 1);
      v6   = tbl_v6[j];
      addr = {tbl_hi[j], tbl_lo[j]};
      if (!v6) addr[127:32] = {rand64(), $urandom()};
      plen = tbl_plen[j];
    end
    send_beat(CMD_INSERT, v6, addr[127:64], addr[63:0], plen);
  endtask

  task automatic send_probe();
    int           j;
    int           p;
    logic         v6;
    logic [127:0] base;
    logic [127:0] keep;
    logic [127:0] addr;
    addr = {rand64(), rand64()};
    v6   = 1'($urandom_range(1));
    if (tbl_count > 0 && $urandom_range(99) < 75) begin
      j  = $urandom_range(tbl_count - 1);
      v6 = tbl_v6[j];
      p  = int'(tbl_plen[j]);
      if (v6) begin
        base = {tbl_hi[j], tbl_lo[j]};
        keep = lead_ones128(p);
      end else begin
        base = {96'd0, tbl_lo[j][31:0]};
        keep = lead_ones128(p) >> 96;
      end
      addr = (base & keep) | (addr & ~keep);
      // Near miss: flip one bit inside the prefix
      if (p > 0 && $urandom_range(99) < 30) begin
        if (v6) addr = addr ^ (128'd1 << (128 - $urandom_range(1, p)));
        else addr = addr ^ (128'd1 << (32 - $urandom_range(1, p)));
      end
    end
    send_beat(CMD_LOOKUP, v6, addr[127:64], addr[63:0], PLEN_W'($urandom()));
  endtask

  task automatic send_noise();
    send_beat(CMD_W'($urandom_range(3)), 1'($urandom_range(1)), rand64(), rand64(),
              PLEN_W'($urandom()));
  endtask

  // Episodes: clear, fill part or all of the table, probe it
  task automatic run_episodes(input int n_items);
    int sent;
    int fill;
    int added;
    int span;
    sent = 0;
    while (sent < n_items) begin
      send_beat(CMD_CLEAR, 1'($urandom_range(1)), rand64(), rand64(), PLEN_W'($urandom()));
      sent++;
      fill  = $urandom_range(0, TABLE_ENTRIES + 4);
      span  = fill + $urandom_range(4, 40);
      added = 0;
      for (int k = 0; k < span && sent < n_items; k++) begin
        if ($urandom_range(99) < 8) begin
          send_noise();
        end else if (added < fill && $urandom_range(1) == 1) begin
          send_insert();
          added++;
        end else begin
          send_probe();
        end
        sent++;
      end
    end
  endtask

  task automatic test_empty_table();
    send_beat(CMD_LOOKUP, 1'b0, '0, '0, '0);
    send_beat(CMD_LOOKUP, 1'b1, '1, '1, '1);
    send_beat(CMD_UNUSED, 1'b1, rand64(), rand64(), 8'd7);
  endtask

  task automatic test_prefix_range();
    send_beat(CMD_INSERT, 1'b0, rand64(), rand64(), PLEN_MAX_V4);
    send_beat(CMD_INSERT, 1'b1, rand64(), rand64(), PLEN_MAX_V6);
    send_beat(CMD_INSERT, 1'b0, rand64(), rand64(), PLEN_MAX_V4 + 8'd1);
    send_beat(CMD_INSERT, 1'b1, rand64(), rand64(), PLEN_MAX_V6 + 8'd1);
    send_beat(CMD_INSERT, 1'b0, '1, '1, 8'd255);
  endtask

  task automatic test_zero_length();
    send_beat(CMD_CLEAR, 1'b0, '0, '0, '0);
    send_beat(CMD_INSERT, 1'b0, rand64(), rand64(), '0);
    send_beat(CMD_LOOKUP, 1'b0, rand64(), rand64(), '0);
    send_beat(CMD_LOOKUP, 1'b1, rand64(), rand64(), '0);
    send_beat(CMD_INSERT, 1'b1, rand64(), rand64(), '0);
    send_beat(CMD_LOOKUP, 1'b1, '1, '1, '0);
  endtask

  task automatic test_match_boundaries();
    logic [ADDR_W-1:0] a_hi;
    logic [ADDR_W-1:0] a_lo;
    logic [ADDR_W-1:0] b_hi;
    logic [ADDR_W-1:0] b_lo;
    a_hi = rand64();
    a_lo = rand64();
    b_hi = rand64();
    b_lo = rand64();
    send_beat(CMD_CLEAR, 1'b1, '1, '1, '1);
    // Full-length host route: exact hit, then last bit off
    send_beat(CMD_INSERT, 1'b1, a_hi, a_lo, PLEN_MAX_V6);
    send_beat(CMD_LOOKUP, 1'b1, a_hi, a_lo, '0);
    send_beat(CMD_LOOKUP, 1'b1, a_hi, a_lo ^ 64'd1, '0);
    // Prefix one bit into the low half
    send_beat(CMD_INSERT, 1'b1, b_hi, b_lo, 8'd65);
    send_beat(CMD_LOOKUP, 1'b1, b_hi, {b_lo[63], ~b_lo[62:0]}, '0);
    send_beat(CMD_LOOKUP, 1'b1, b_hi, {~b_lo[63], b_lo[62:0]}, '0);
    // IPv4 ignores the upper address bits on both insert and lookup
    send_beat(CMD_INSERT, 1'b0, '1, '1, PLEN_MAX_V4);
    send_beat(CMD_LOOKUP, 1'b0, rand64(), {$urandom(), 32'hFFFF_FFFF}, '0);
    // Duplicate entry
    send_beat(CMD_INSERT, 1'b1, a_hi, a_lo, PLEN_MAX_V6);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 10;
    recv_idle_pct = 51;
    run_episodes(670);
    wait_for_results();
    send_idle_pct = 51;
    recv_idle_pct = 10;
    run_episodes(670);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_episodes(670);
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_LOOKUP;
    in_ch.is_ipv6       = 1'b0;
    in_ch.address_high  = '0;
    in_ch.address_low   = '0;
    in_ch.prefix_length = '0;
    out_ch.ready        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 51;
    test_empty_table();
    test_prefix_range();
    test_zero_length();
    test_match_boundaries();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    // Let any stray beat show up
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
